// ----- design/refcounted_subscription_table_unit_assert.svh -----
// Assertion macros for the subscription table unit.
`ifndef REFCOUNTED_SUBSCRIPTION_TABLE_UNIT_ASSERT_SVH
`define REFCOUNTED_SUBSCRIPTION_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define RSTU_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rstu assertion failed");

// Next-cycle implication, checked out of reset.
`define RSTU_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rstu assertion failed");

`endif

// ----- design/rstu_pkg.sv -----
// Package: types, codes and sizes of the subscription table unit.
`timescale 1ns / 1ps
package rstu_pkg;

  localparam int TABLE_DEPTH = 64;
  localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = 7;
  localparam int NUM_EXCL    = 7;
  localparam int CFG_IDX_W   = 3;
  localparam int ID_W        = 16;
  localparam int QOS_W       = 16;
  localparam int USES_W      = 16;
  localparam int ENTRY_W     = ID_W + QOS_W + USES_W;

  typedef enum logic [1:0] {
    CMD_SUB   = 2'd0,
    CMD_UNSUB = 2'd1,
    CMD_LIST  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_COUNTED   = 3'd0,
    ST_NEW       = 3'd1,
    ST_REMOVED   = 3'd2,
    ST_EXCLUDED  = 3'd3,
    ST_FULL      = 3'd4,
    ST_NOT_FOUND = 3'd5,
    ST_LISTED    = 3'd6,
    ST_EMPTY     = 3'd7
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT,
    S_LIST_RD,
    S_LIST_OUT,
    S_RESP
  } state_e;

  // Table entry: qos holds priority in the low byte, reliability in the high byte.
  typedef struct packed {
    logic [USES_W-1:0] uses;
    logic [QOS_W-1:0]  qos;
    logic [ID_W-1:0]   id;
  } entry_t;

endpackage

// ----- design/rstu_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module rstu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [AW-1:0]            waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [AW-1:0]            raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, held while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

// ----- design/refcounted_subscription_table_unit.sv -----
// Top level: reference-counted subscription table with one entry RAM.
//
// Usage:
// - Input channel (in_valid_i / in_ready_o) carries a command, a message ID
//   and two QoS bytes. Ready is high only while the unit is idle; one command
//   is worked on at a time.
// - Output channel (out_valid_o / out_ready_i) is a single output register;
//   each subscribe or unsubscribe gives one result, a list gives one result
//   per entry with last_o on the final one (or one empty result).
// - Configuration: cfg_we_i writes one of seven excluded IDs selected by
//   cfg_idx_i; write only while idle.
// Command processing:
// - subscribe/unsubscribe: a linear search over the valid entries reads one
//   RAM entry per cycle through the read port, up to a hit or the end.
// - removal adds shift compaction of the entries after the hit (read one,
//   write one).
// - list: one RAM read and one output load per entry.
// Reset empties the table at once (fill count to zero) and clears the
// excluded IDs; no clearing pass. A stalled receiver holds the output
// register; the unit holds its next result back but accepts commands when idle.
`timescale 1ns / 1ps
module refcounted_subscription_table_unit
  import rstu_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           command_i,
  input  logic [15:0]          msg_id_i,
  input  logic [7:0]           qos_priority_i,
  input  logic [7:0]           qos_reliability_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [2:0]           status_o,
  output logic [15:0]          out_msg_id_o,
  output logic [7:0]           out_qos_priority_o,
  output logic [7:0]           out_qos_reliability_o,
  output logic [15:0]          use_count_o,
  output logic [6:0]           entry_count_o,
  output logic                 last_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [15:0]          cfg_wdata_i
);

  state_e state_q, state_d;
  logic [CNT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0] cmp_idx_q, cmp_idx_d;
  logic             cmp_vld_q, cmp_vld_d;
  logic [CNT_W-1:0] count_q, count_d;

  cmd_e             cmd_q;
  logic [ID_W-1:0]  id_q;
  logic [QOS_W-1:0] qos_q;

  status_e           res_status_q, res_status_d;
  logic [ID_W-1:0]   res_id_q, res_id_d;
  logic [QOS_W-1:0]  res_qos_q, res_qos_d;
  logic [USES_W-1:0] res_uses_q, res_uses_d;

  logic [ID_W-1:0] excl_q [NUM_EXCL];

  logic              out_valid_q, out_valid_d;
  status_e           out_status_q, out_status_d;
  logic [ID_W-1:0]   out_id_q, out_id_d;
  logic [QOS_W-1:0]  out_qos_q, out_qos_d;
  logic [USES_W-1:0] out_uses_q, out_uses_d;
  logic [CNT_W-1:0]  out_count_q, out_count_d;
  logic              out_last_q, out_last_d;
  logic              out_load, out_free;

  logic              ram_we, ram_re;
  logic [ADDR_W-1:0] ram_waddr, ram_raddr;
  entry_t            ram_wdata, ram_rdata;

  logic              in_xfer, excluded, hit;
  logic [CNT_W-1:0]  shift_dst;
  logic [USES_W-1:0] uses_inc, uses_dec;

  rstu_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_entry_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  // Match the incoming ID against the excluded list
  always_comb begin
    excluded = 1'b0;
    for (int k = 0; k < NUM_EXCL; k++) begin
      if (excl_q[k] == msg_id_i) begin
        excluded = 1'b1;
      end
    end
  end

  assign hit       = cmp_vld_q && (ram_rdata.id == id_q);
  assign uses_inc  = (ram_rdata.uses == '1) ? ram_rdata.uses : ram_rdata.uses + USES_W'(1);
  assign uses_dec  = ram_rdata.uses - USES_W'(1);
  assign shift_dst = cmp_idx_q - CNT_W'(1);

  // Next state, RAM control and result staging
  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    cmp_idx_d    = cmp_idx_q;
    cmp_vld_d    = cmp_vld_q;
    count_d      = count_q;
    res_status_d = res_status_q;
    res_id_d     = res_id_q;
    res_qos_d    = res_qos_q;
    res_uses_d   = res_uses_q;
    ram_we       = 1'b0;
    ram_waddr    = cmp_idx_q[ADDR_W-1:0];
    ram_wdata    = ram_rdata;
    ram_re       = 1'b0;
    ram_raddr    = idx_q[ADDR_W-1:0];
    out_load     = 1'b0;
    out_status_d = res_status_q;
    out_id_d     = res_id_q;
    out_qos_d    = res_qos_q;
    out_uses_d   = res_uses_q;
    out_last_d   = 1'b1;

    unique case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          idx_d     = '0;
          cmp_vld_d = 1'b0;
          res_id_d  = msg_id_i;
          res_qos_d = '0;
          res_uses_d = '0;
          case (cmd_e'(command_i))
            CMD_SUB: begin
              if (excluded) begin
                res_status_d = ST_EXCLUDED;
                state_d      = S_RESP;
              end else begin
                state_d = S_SEARCH;
              end
            end
            CMD_UNSUB: begin
              state_d = S_SEARCH;
            end
            CMD_LIST: begin
              if (count_q == '0) begin
                res_status_d = ST_EMPTY;
                res_id_d     = '0;
                state_d      = S_RESP;
              end else begin
                state_d = S_LIST_RD;
              end
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end

      S_SEARCH: begin
        if (hit) begin
          cmp_vld_d = 1'b0;
          res_qos_d = ram_rdata.qos;
          if (cmd_q == CMD_SUB) begin
            ram_we         = 1'b1;
            ram_wdata.uses = uses_inc;
            res_status_d   = ST_COUNTED;
            res_uses_d     = uses_inc;
            state_d        = S_RESP;
          end else if (ram_rdata.uses > USES_W'(1)) begin
            ram_we         = 1'b1;
            ram_wdata.uses = uses_dec;
            res_status_d   = ST_COUNTED;
            res_uses_d     = uses_dec;
            state_d        = S_RESP;
          end else begin
            res_status_d = ST_REMOVED;
            res_uses_d   = '0;
            idx_d        = cmp_idx_q + CNT_W'(1);
            state_d      = S_SHIFT;
          end
        end else if (idx_q < count_q) begin
          // Issue the next read; compare it next cycle
          ram_re    = 1'b1;
          cmp_idx_d = idx_q;
          cmp_vld_d = 1'b1;
          idx_d     = idx_q + CNT_W'(1);
        end else begin
          cmp_vld_d = 1'b0;
          if (!cmp_vld_q) begin
            if (cmd_q != CMD_SUB) begin
              res_status_d = ST_NOT_FOUND;
            end else if (count_q >= CNT_W'(TABLE_DEPTH)) begin
              res_status_d = ST_FULL;
            end else begin
              // Append at the end of the table
              ram_we         = 1'b1;
              ram_waddr      = count_q[ADDR_W-1:0];
              ram_wdata.id   = id_q;
              ram_wdata.qos  = qos_q;
              ram_wdata.uses = USES_W'(1);
              count_d        = count_q + CNT_W'(1);
              res_status_d   = ST_NEW;
              res_qos_d      = qos_q;
              res_uses_d     = USES_W'(1);
            end
            state_d = S_RESP;
          end
        end
      end

      S_SHIFT: begin
        // Move the entry read last cycle one place down
        if (cmp_vld_q) begin
          ram_we    = 1'b1;
          ram_waddr = shift_dst[ADDR_W-1:0];
        end
        if (idx_q < count_q) begin
          ram_re    = 1'b1;
          cmp_idx_d = idx_q;
          cmp_vld_d = 1'b1;
          idx_d     = idx_q + CNT_W'(1);
        end else begin
          cmp_vld_d = 1'b0;
          if (!cmp_vld_q) begin
            count_d = count_q - CNT_W'(1);
            state_d = S_RESP;
          end
        end
      end

      S_LIST_RD: begin
        ram_re  = 1'b1;
        state_d = S_LIST_OUT;
      end

      S_LIST_OUT: begin
        if (out_free) begin
          out_load     = 1'b1;
          out_status_d = ST_LISTED;
          out_id_d     = ram_rdata.id;
          out_qos_d    = ram_rdata.qos;
          out_uses_d   = ram_rdata.uses;
          out_last_d   = ((idx_q + CNT_W'(1)) == count_q);
          idx_d        = idx_q + CNT_W'(1);
          state_d      = out_last_d ? S_IDLE : S_LIST_RD;
        end
      end

      S_RESP: begin
        if (out_free) begin
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign out_count_d = count_q;
  assign out_valid_d = out_load || (out_valid_q && !out_ready_i);

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      idx_q       <= '0;
      cmp_idx_q   <= '0;
      cmp_vld_q   <= 1'b0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      idx_q       <= idx_d;
      cmp_idx_q   <= cmp_idx_d;
      cmp_vld_q   <= cmp_vld_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Excluded ID registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_EXCL; k++) begin
        excl_q[k] <= '0;
      end
    end else if (cfg_we_i && (cfg_idx_i < CFG_IDX_W'(NUM_EXCL))) begin
      excl_q[cfg_idx_i] <= cfg_wdata_i;
    end
  end

  // Capture the command on transfer
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      cmd_q <= cmd_e'(command_i);
      id_q  <= msg_id_i;
      qos_q <= {qos_reliability_i, qos_priority_i};
    end
  end

  // Staged result and output register payload
  always_ff @(posedge clk_i) begin
    res_status_q <= res_status_d;
    res_id_q     <= res_id_d;
    res_qos_q    <= res_qos_d;
    res_uses_q   <= res_uses_d;
    if (out_load) begin
      out_status_q <= out_status_d;
      out_id_q     <= out_id_d;
      out_qos_q    <= out_qos_d;
      out_uses_q   <= out_uses_d;
      out_count_q  <= out_count_d;
      out_last_q   <= out_last_d;
    end
  end

  assign out_valid_o           = out_valid_q;
  assign status_o              = out_status_q;
  assign out_msg_id_o          = out_id_q;
  assign out_qos_priority_o    = out_qos_q[7:0];
  assign out_qos_reliability_o = out_qos_q[15:8];
  assign use_count_o           = out_uses_q;
  assign entry_count_o         = out_count_q;
  assign last_o                = out_last_q;

  `include "refcounted_subscription_table_unit_assert.svh"

  `RSTU_ASSERT_NOW(a_count_bound, 1'b1, count_q <= CNT_W'(TABLE_DEPTH))
  `RSTU_ASSERT_NOW(a_write_when_busy, ram_we, (state_q == S_SEARCH) || (state_q == S_SHIFT))
  `RSTU_ASSERT_NEXT(a_count_idle_hold, state_q == S_IDLE, count_q == $past(count_q))
  `RSTU_ASSERT_NOW(a_load_needs_slot, out_load, out_free)

endmodule

// ----- tb/sv/tb_refcounted_subscription_table_unit.sv -----
// Testbench for the subscription table unit: self-checking stimulus and scoreboard.
`timescale 1ns / 1ps
module tb_refcounted_subscription_table_unit;
  import rstu_pkg::*;

  localparam int STALL_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 16;
  localparam int TAIL_CYCLES   = 150;
  localparam int EXCL_CMD_IDX     = 0;
  localparam int EXCL_PEER_HK_IDX = 3;

  // One result as seen on the output channel
  typedef struct {
    logic [2:0]  status;
    logic [15:0] id;
    logic [7:0]  pri;
    logic [7:0]  rel;
    logic [15:0] uses;
    logic [6:0]  fill;
    logic        last;
  } reply_t;

  // Mirror of the subscription table; predicts the replies of each command
  class subscription_tracker;
    bit [15:0]   excl_ids [NUM_EXCL];
    bit [15:0]   ids  [TABLE_DEPTH];
    bit [15:0]   qos  [TABLE_DEPTH];
    bit [15:0]   uses [TABLE_DEPTH];
    int          fill;
    reply_t      pending_replies [$];
    int          failures;

    function new();
      foreach (excl_ids[i]) excl_ids[i] = '0;
      fill     = 0;
      failures = 0;
    endfunction

    function void set_exclusion(int idx, bit [15:0] value);
      excl_ids[idx] = value;
    endfunction

    function int outstanding();
      return pending_replies.size();
    endfunction

    // Return an ID currently in the table, or a random one when empty
    function bit [15:0] pick_id();
      if (fill == 0) begin
        return 16'($urandom);
      end
      return ids[$urandom_range(0, fill - 1)];
    endfunction

    function int find_slot(bit [15:0] id);
      for (int i = 0; i < fill; i++) begin
        if (ids[i] == id) begin
          return i;
        end
      end
      return -1;
    endfunction

    function void push_reply(logic [2:0] st, bit [15:0] id, bit [15:0] q, bit [15:0] u,
                             bit lst);
      reply_t r;
      r.status = st;
      r.id     = id;
      r.pri    = q[7:0];
      r.rel    = q[15:8];
      r.uses   = u;
      r.fill   = 7'(fill);
      r.last   = lst;
      pending_replies.push_back(r);
    endfunction

    // Apply one accepted command to the mirror and queue its replies
    function void note_command(logic [1:0] cmd, bit [15:0] id, bit [7:0] pri, bit [7:0] rel);
      int        slot;
      bit        blocked;
      bit [15:0] q;
      q = {rel, pri};
      case (cmd)
        CMD_SUB: begin
          blocked = 1'b0;
          foreach (excl_ids[i]) if (excl_ids[i] == id) blocked = 1'b1;
          slot = find_slot(id);
          if (blocked) begin
            push_reply(ST_EXCLUDED, id, '0, '0, 1'b1);
          end else if (slot >= 0) begin
            // saturate the use count
            if (uses[slot] != 16'hFFFF) uses[slot]++;
            push_reply(ST_COUNTED, id, qos[slot], uses[slot], 1'b1);
          end else if (fill >= TABLE_DEPTH) begin
            push_reply(ST_FULL, id, '0, '0, 1'b1);
          end else begin
            ids[fill]  = id;
            qos[fill]  = q;
            uses[fill] = 16'd1;
            fill++;
            push_reply(ST_NEW, id, q, 16'd1, 1'b1);
          end
        end
        CMD_UNSUB: begin
          slot = find_slot(id);
          if (slot < 0) begin
            push_reply(ST_NOT_FOUND, id, '0, '0, 1'b1);
          end else if (uses[slot] > 16'd1) begin
            uses[slot]--;
            push_reply(ST_COUNTED, id, qos[slot], uses[slot], 1'b1);
          end else begin
            // drop the entry and close the gap
            q = qos[slot];
            for (int i = slot; i + 1 < fill; i++) begin
              ids[i]  = ids[i + 1];
              qos[i]  = qos[i + 1];
              uses[i] = uses[i + 1];
            end
            fill--;
            push_reply(ST_REMOVED, id, q, '0, 1'b1);
          end
        end
        CMD_LIST: begin
          if (fill == 0) begin
            push_reply(ST_EMPTY, '0, '0, '0, 1'b1);
          end else begin
            for (int i = 0; i < fill; i++) begin
              push_reply(ST_LISTED, ids[i], qos[i], uses[i], i + 1 == fill);
            end
          end
        end
        default: begin
        end
      endcase
    endfunction

    function void check_field(string name, logic [15:0] want, logic [15:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        failures++;
      end
    endfunction

    // Compare one transfer on the output channel with the oldest expectation
    function void check_reply(reply_t got);
      reply_t want;
      if (pending_replies.size() == 0) begin
        $error("unexpected result: status %0d, out_msg_id %0h", got.status, got.id);
        failures++;
        return;
      end
      want = pending_replies.pop_front();
      check_field("status", 16'(want.status), 16'(got.status));
      check_field("out_msg_id", want.id, got.id);
      check_field("out_qos_priority", 16'(want.pri), 16'(got.pri));
      check_field("out_qos_reliability", 16'(want.rel), 16'(got.rel));
      check_field("use_count", want.uses, got.uses);
      check_field("entry_count", 16'(want.fill), 16'(got.fill));
      check_field("last", 16'(want.last), 16'(got.last));
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  command = CMD_NONE;
  logic [15:0] msg_id = '0;
  logic [7:0]  qos_pri = '0;
  logic [7:0]  qos_rel = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  status;
  logic [15:0] out_msg_id;
  logic [7:0]  out_pri;
  logic [7:0]  out_rel;
  logic [15:0] use_count;
  logic [6:0]  entry_count;
  logic        last;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [15:0]          cfg_wdata = '0;

  subscription_tracker tracker;
  reply_t      seen_reply;
  bit [15:0]   excl_plan [NUM_EXCL];
  int          idle_cycles = 0;
  int          burst_left = 0;
  bit          offer_up = 1'b0;
  bit          tx_gap_en = 1'b1;
  bit          rx_stall_en = 1'b1;
  logic [9:0]  rx_cycle = '0;
  int          rx_hold = 0;

  refcounted_subscription_table_unit DUT (
    .clk_i                 (clk),
    .rst_ni                (rst_n),
    .in_valid_i            (in_valid),
    .in_ready_o            (in_ready),
    .command_i             (command),
    .msg_id_i              (msg_id),
    .qos_priority_i        (qos_pri),
    .qos_reliability_i     (qos_rel),
    .out_valid_o           (out_valid),
    .out_ready_i           (out_ready),
    .status_o              (status),
    .out_msg_id_o          (out_msg_id),
    .out_qos_priority_o    (out_pri),
    .out_qos_reliability_o (out_rel),
    .use_count_o           (use_count),
    .entry_count_o         (entry_count),
    .last_o                (last),
    .cfg_we_i              (cfg_we),
    .cfg_idx_i             (cfg_idx),
    .cfg_wdata_i           (cfg_wdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Receiver: random stalls, with calm windows where it never stalls
  always @(posedge clk) begin
    rx_cycle <= rx_cycle + 10'd1;
    if (!rx_stall_en || rx_cycle[9]) begin
      out_ready <= 1'b1;
    end else if (rx_hold != 0) begin
      out_ready <= 1'b0;
      rx_hold   <= rx_hold - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      out_ready <= 1'b0;
      rx_hold   <= $urandom_range(0, 11);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Check output transfers and watch for a hung block
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && out_ready) begin
        seen_reply.status = status;
        seen_reply.id     = out_msg_id;
        seen_reply.pri    = out_pri;
        seen_reply.rel    = out_rel;
        seen_reply.uses   = use_count;
        seen_reply.fill   = entry_count;
        seen_reply.last   = last;
        tracker.check_reply(seen_reply);
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles == STALL_LIMIT) begin
        $display("*** FAILED ***");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // Offer one command, sometimes idling first at burst boundaries; hold until the transfer
  task automatic send_command(input logic [1:0] cmd, input logic [15:0] id,
                              input logic [7:0] pri, input logic [7:0] rel);
    int gap;
    gap = 0;
    if (tx_gap_en) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 20);
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
      end else begin
        burst_left--;
      end
    end
    if (gap > 0) begin
      if (offer_up) begin
        in_valid <= 1'b0;
        offer_up = 1'b0;
      end
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command  <= cmd;
    msg_id   <= id;
    qos_pri  <= pri;
    qos_rel  <= rel;
    offer_up = 1'b1;
    do @(posedge clk); while (!in_ready);
    tracker.note_command(cmd, id, pri, rel);
  endtask

  task automatic idle_input();
    if (offer_up) begin
      in_valid <= 1'b0;
      offer_up = 1'b0;
      @(posedge clk);
    end
  endtask

  // Hold off the sender until every expected result has arrived
  task automatic settle_table();
    idle_input();
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write all excluded IDs from excl_plan, one per cycle
  task automatic program_exclusions();
    for (int k = 0; k < NUM_EXCL; k++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= CFG_IDX_W'(k);
      cfg_wdata <= excl_plan[k];
      tracker.set_exclusion(k, excl_plan[k]);
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Small ID pool: heavy counting up and down, removals and lists
  task automatic run_churn(input int n_items);
    bit [15:0]   pool [12];
    int          done;
    int          roll;
    bit          paused;
    cmd_e        cmd;
    logic [15:0] id;
    foreach (pool[i]) pool[i] = 16'($urandom);
    pool[0] = excl_plan[EXCL_PEER_HK_IDX];
    done   = 0;
    paused = 1'b0;
    while (done < n_items) begin
      roll = $urandom_range(0, 99);
      id   = pool[$urandom_range(0, 11)];
      if (roll < 45) begin
        cmd = CMD_SUB;
      end else if (roll < 80) begin
        cmd = CMD_UNSUB;
      end else if (roll < 88) begin
        cmd = CMD_LIST;
      end else if (roll < 95) begin
        cmd = roll[0] ? CMD_SUB : CMD_UNSUB;
        id  = 16'($urandom);
      end else begin
        cmd = CMD_NONE;
        id  = 16'($urandom);
      end
      send_command(cmd, id, 8'($urandom), 8'($urandom));
      if (cmd != CMD_NONE) done++;
      if (!paused && done >= n_items / 2) begin
        settle_table();
        paused = 1'b1;
      end
    end
  endtask

  // Mostly fresh subscribes: fill the table and run into the full case
  task automatic run_fill(input int n_items);
    int          roll;
    cmd_e        cmd;
    logic [15:0] id;
    for (int n = 0; n < n_items; n++) begin
      roll = $urandom_range(0, 99);
      id   = 16'($urandom);
      cmd  = CMD_SUB;
      if (roll >= 97) begin
        cmd = CMD_UNSUB;
        id  = tracker.pick_id();
      end else if (roll >= 93) begin
        cmd = CMD_LIST;
      end else if (roll >= 90) begin
        id = 16'h0000;
      end else if (roll >= 84) begin
        id = tracker.pick_id();
      end
      send_command(cmd, id, 8'($urandom), 8'($urandom));
    end
  endtask

  // Mostly unsubscribes of present entries: empty the table again
  task automatic run_drain(input int n_items);
    int          done;
    int          roll;
    cmd_e        cmd;
    logic [15:0] id;
    done = 0;
    while (done < n_items) begin
      roll = $urandom_range(0, 99);
      id   = tracker.pick_id();
      if (roll < 70) begin
        cmd = CMD_UNSUB;
      end else if (roll < 80) begin
        cmd = CMD_SUB;
      end else if (roll < 88) begin
        cmd = CMD_LIST;
      end else if (roll < 94) begin
        cmd = CMD_UNSUB;
        id  = 16'($urandom);
      end else if (roll < 97) begin
        cmd = CMD_SUB;
        id  = 16'($urandom);
      end else begin
        cmd = CMD_NONE;
      end
      send_command(cmd, id, 8'($urandom), 8'($urandom));
      if (cmd != CMD_NONE) done++;
    end
  endtask

  initial begin
    tracker = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Excluded IDs all zero after reset: empty table, misses, removal in each position
    send_command(CMD_LIST, 16'h0000, 8'h00, 8'h00);
    send_command(CMD_UNSUB, 16'h0005, 8'h00, 8'h00);
    send_command(CMD_SUB, 16'h0000, 8'h12, 8'h34);
    send_command(CMD_UNSUB, 16'h0000, 8'h00, 8'h00);
    send_command(CMD_NONE, 16'hABCD, 8'hFF, 8'hFF);
    send_command(CMD_SUB, 16'hFFFF, 8'hFF, 8'h00);
    send_command(CMD_SUB, 16'h1234, 8'h00, 8'hFF);
    send_command(CMD_SUB, 16'h0001, 8'hA5, 8'h5A);
    send_command(CMD_SUB, 16'h1234, 8'h77, 8'h77);
    send_command(CMD_LIST, 16'h0000, 8'h00, 8'h00);
    send_command(CMD_UNSUB, 16'h1234, 8'h00, 8'h00);
    send_command(CMD_UNSUB, 16'h1234, 8'h00, 8'h00);
    send_command(CMD_LIST, 16'hFFFF, 8'hFF, 8'hFF);
    send_command(CMD_UNSUB, 16'hFFFF, 8'h00, 8'h00);
    send_command(CMD_UNSUB, 16'h0001, 8'h00, 8'h00);
    send_command(CMD_LIST, 16'h0000, 8'h00, 8'h00);
    settle_table();

    // Distinct excluded IDs, extremes among them
    excl_plan = '{16'hFFFF, 16'h0800, 16'h0801, 16'h1FFF, 16'h2000, 16'h7FFF, 16'h8000};
    program_exclusions();
    send_command(CMD_SUB, 16'hFFFF, 8'h01, 8'h02);
    send_command(CMD_UNSUB, 16'hFFFF, 8'h00, 8'h00);
    send_command(CMD_SUB, 16'h8000, 8'h03, 8'h04);
    send_command(CMD_SUB, 16'h0000, 8'h11, 8'h22);

    // Count one entry up and down at full rate
    tx_gap_en   = 1'b0;
    rx_stall_en = 1'b0;
    repeat (6) send_command(CMD_SUB, 16'h0000, 8'h11, 8'h22);
    send_command(CMD_SUB, 16'h0000, 8'h11, 8'h22);
    send_command(CMD_UNSUB, 16'h0000, 8'h00, 8'h00);
    send_command(CMD_LIST, 16'h0000, 8'h00, 8'h00);
    settle_table();
    tx_gap_en   = 1'b1;
    rx_stall_en = 1'b1;

    // Random excluded IDs; one of them sits in the churn pool
    foreach (excl_plan[k]) excl_plan[k] = 16'($urandom);
    program_exclusions();
    run_churn(130);
    settle_table();

    // Exclude an ID that is already in the table
    foreach (excl_plan[k]) excl_plan[k] = 16'($urandom);
    excl_plan[EXCL_CMD_IDX] = 16'h0000;
    program_exclusions();
    run_fill(100);
    settle_table();

    foreach (excl_plan[k]) excl_plan[k] = 16'hFFFF;
    program_exclusions();
    run_drain(140);

    settle_table();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (tracker.failures == 0 && tracker.outstanding() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
